// ----- rtl/ctf_pkg.sv -----
// Shared constants, register codes, config struct and the CORDIC angle table
// for the complementary tilt filter. No dependencies.
package ctf_pkg;

    localparam int ANGLE_FRAC_BITS = 16;  // fraction bits of every angle (8..24)
    localparam int CORDIC_STEPS    = 16;  // CORDIC iterations (8..24)

    localparam int TBL_FRAC  = 24;
    localparam int RAW_W     = 16;
    localparam int DIFF_W    = 17;
    localparam int ANGLE_W   = 32;
    localparam int IDX_W     = 3;
    localparam int CNT_W     = 5;
    localparam int ALPHA_W   = 16;
    localparam int ALPHA_ONE = 32768;

    // square root of (sum of squares << 24)
    localparam int SQ_SHIFT  = 24;
    localparam int NSQ_W     = 57;
    localparam int Y_SHIFT   = 12;

    localparam int RND_SH    = (TBL_FRAC > ANGLE_FRAC_BITS) ? TBL_FRAC - ANGLE_FRAC_BITS : 0;
    localparam int RND_ADD   = (RND_SH > 0) ? (1 << (RND_SH - 1)) : 0;

    // gyro step: (|g| * dt << F + GYRO_HALF) / GYRO_DIV
    localparam int DIVD_W    = ANGLE_FRAC_BITS + 34;
    localparam int QUO_W     = ANGLE_FRAC_BITS + 7;
    localparam longint GYRO_DIV  = 131000000;
    localparam longint GYRO_HALF = 65500000;

    // quotient estimate: ((dividend >> GQ_SHIFT) * GYRO_RECIP) >> RECIP_SH,
    // low by at most one, then one compare against GYRO_DIV
    localparam int GQ_SHIFT  = ANGLE_FRAC_BITS - 1;
    localparam int RECIP_SH  = 60 - ANGLE_FRAC_BITS;
    localparam longint GYRO_RECIP = 64'd4400463758;  // floor(2^59 / GYRO_DIV)

    localparam int MUL_A_W   = 34;
    localparam int MUL_B_W   = 34;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;

    localparam logic [IDX_W-1:0] REG_ACC_OFF_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_ACC_OFF_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_ACC_OFF_Z = 3'd2;
    localparam logic [IDX_W-1:0] REG_GYR_OFF_X = 3'd3;
    localparam logic [IDX_W-1:0] REG_GYR_OFF_Y = 3'd4;
    localparam logic [IDX_W-1:0] REG_GYR_OFF_Z = 3'd5;
    localparam logic [IDX_W-1:0] REG_GYR_WEIGHT = 3'd6;

    typedef struct packed {
        logic signed [RAW_W-1:0] acc_off_x;
        logic signed [RAW_W-1:0] acc_off_y;
        logic signed [RAW_W-1:0] acc_off_z;
        logic signed [RAW_W-1:0] gyr_off_x;
        logic signed [RAW_W-1:0] gyr_off_y;
        logic signed [RAW_W-1:0] gyr_off_z;
        logic [ALPHA_W-1:0]      alpha;      // already clamped to 32768
    } ctf_cfg_t;

    // atan(2^-i) in degrees, 24 fraction bits
    function automatic logic signed [31:0] atan_deg(input logic [CNT_W-1:0] idx);
        logic signed [31:0] v;
        begin
            case (idx)
                5'd0:  v = 32'sd754974720;
                5'd1:  v = 32'sd445687602;
                5'd2:  v = 32'sd235489089;
                5'd3:  v = 32'sd119537938;
                5'd4:  v = 32'sd60000934;
                5'd5:  v = 32'sd30029717;
                5'd6:  v = 32'sd15018523;
                5'd7:  v = 32'sd7509720;
                5'd8:  v = 32'sd3754917;
                5'd9:  v = 32'sd1877466;
                5'd10: v = 32'sd938734;
                5'd11: v = 32'sd469367;
                5'd12: v = 32'sd234684;
                5'd13: v = 32'sd117342;
                5'd14: v = 32'sd58671;
                5'd15: v = 32'sd29335;
                5'd16: v = 32'sd14668;
                5'd17: v = 32'sd7334;
                5'd18: v = 32'sd3667;
                5'd19: v = 32'sd1833;
                5'd20: v = 32'sd917;
                5'd21: v = 32'sd458;
                5'd22: v = 32'sd229;
                5'd23: v = 32'sd115;
                default: v = 32'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ----- rtl/ctf_cfg_regs.sv -----
// Configuration register file of the tilt filter: offsets and gyro weight.
// Depends on ctf_pkg.
module ctf_cfg_regs (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      wr_en,
    input  logic [ctf_pkg::IDX_W-1:0] index,
    input  logic [ctf_pkg::RAW_W-1:0] wr_data,
    output ctf_pkg::ctf_cfg_t         cfg
);
    import ctf_pkg::*;

    ctf_cfg_t cfg_reg;
    logic [ALPHA_W-1:0] alpha_next;

    // clamp weight above one
    assign alpha_next = (wr_data > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : wr_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.acc_off_x <= 16'sd802;
            cfg_reg.acc_off_y <= -16'sd368;
            cfg_reg.acc_off_z <= -16'sd1195;
            cfg_reg.gyr_off_x <= -16'sd482;
            cfg_reg.gyr_off_y <= 16'sd252;
            cfg_reg.gyr_off_z <= -16'sd69;
            cfg_reg.alpha     <= 16'd31130;
        end else if (wr_en) begin
            case (index)
                REG_ACC_OFF_X:  cfg_reg.acc_off_x <= wr_data;
                REG_ACC_OFF_Y:  cfg_reg.acc_off_y <= wr_data;
                REG_ACC_OFF_Z:  cfg_reg.acc_off_z <= wr_data;
                REG_GYR_OFF_X:  cfg_reg.gyr_off_x <= wr_data;
                REG_GYR_OFF_Y:  cfg_reg.gyr_off_y <= wr_data;
                REG_GYR_OFF_Z:  cfg_reg.gyr_off_z <= wr_data;
                REG_GYR_WEIGHT: cfg_reg.alpha     <= alpha_next;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/complementary_tilt_filter_core.sv -----
// Complementary tilt filter core: sequencer around one shared 34x34 multiplier,
// a bit-serial square root, a CORDIC and a reciprocal-multiply gyro scaler.
// Depends on ctf_pkg and ctf_cfg_regs.
//
//   channel  | handshake          | word
//   ---------+--------------------+----------------------------------------
//   input    | s_valid / s_ready  | first_sample, accel xyz, gyro xyz, dt
//   result   | m_valid / m_ready  | roll_deg, pitch_deg, yaw_deg
//   config   | cfg_wr_en          | cfg_index, cfg_wr_data
//
// Each tilt runs the squares, the root bits, the CORDIC and the rounding in
// turn; a first-sample word shows its result after two tilts, any other word
// adds 3 gyro steps (product, estimate, correction) and the blend.
// The result then waits for m_ready, after which the core returns to idle.
// s_ready is high only while the core is idle; reset clears the angles.
module complementary_tilt_filter_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [ctf_pkg::IDX_W-1:0]        cfg_index,
    input  logic [ctf_pkg::RAW_W-1:0]        cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_first_sample,
    input  logic signed [ctf_pkg::RAW_W-1:0] s_accel_x,
    input  logic signed [ctf_pkg::RAW_W-1:0] s_accel_y,
    input  logic signed [ctf_pkg::RAW_W-1:0] s_accel_z,
    input  logic signed [ctf_pkg::RAW_W-1:0] s_gyro_x,
    input  logic signed [ctf_pkg::RAW_W-1:0] s_gyro_y,
    input  logic signed [ctf_pkg::RAW_W-1:0] s_gyro_z,
    input  logic [ctf_pkg::RAW_W-1:0]        s_elapsed_us,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [ctf_pkg::ANGLE_W-1:0] m_roll_deg,
    output logic signed [ctf_pkg::ANGLE_W-1:0] m_pitch_deg,
    output logic signed [ctf_pkg::ANGLE_W-1:0] m_yaw_deg
);
    import ctf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SQP, S_SQQ, S_ROOT, S_CORD, S_TILT,
        S_GMUL, S_GREC, S_GCHK, S_BL1, S_BL2, S_OUT
    } state_t;

    ctf_cfg_t cfg;

    ctf_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cfg_wr_en),
        .index   (cfg_index),
        .wr_data (cfg_wr_data),
        .cfg     (cfg)
    );

    state_t state_reg;
    logic   m_valid_reg;
    logic   first_reg;
    logic   tsel_reg;
    logic   bsel_reg;
    logic [1:0]       gsel_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic signed [DIFF_W-1:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg, gz_reg;
    logic [RAW_W-1:0]         dt_reg;

    logic signed [PROD_W-1:0] acc_reg;
    logic [NSQ_W-1:0]         n_reg, r_reg, b_reg;
    logic signed [31:0]       x_reg, y_reg, z_reg;
    logic [DIVD_W-1:0]        rem_reg;
    logic [QUO_W-1:0]         quo_reg;

    logic signed [ANGLE_W-1:0] acc_roll_reg, acc_pitch_reg;
    logic signed [ANGLE_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [ANGLE_W-1:0] roll_reg, pitch_reg, yaw_reg;

    // ---- operand selection ----
    logic signed [DIFF_W-1:0] num_sel, p_sel, g_sel;
    logic [DIFF_W-1:0]        g_mag;
    logic signed [ANGLE_W-1:0] ang_sel, dlt_sel, accel_sel;

    always_comb begin
        num_sel = tsel_reg ? ay_reg : ax_reg;
        p_sel   = tsel_reg ? ax_reg : ay_reg;
        case (gsel_reg)
            2'd0:    g_sel = gx_reg;
            2'd1:    g_sel = gy_reg;
            default: g_sel = gz_reg;
        endcase
        g_mag     = g_sel[DIFF_W-1] ? DIFF_W'(-g_sel) : DIFF_W'(g_sel);
        ang_sel   = bsel_reg ? pitch_reg : roll_reg;
        dlt_sel   = bsel_reg ? dy_reg : dx_reg;
        accel_sel = bsel_reg ? acc_pitch_reg : acc_roll_reg;
    end

    // ---- shared multiplier ----
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    always_comb begin
        case (state_reg)
            S_SQP: begin
                mul_a = MUL_A_W'(p_sel);
                mul_b = MUL_B_W'(p_sel);
            end
            S_SQQ: begin
                mul_a = MUL_A_W'(az_reg);
                mul_b = MUL_B_W'(az_reg);
            end
            S_GMUL: begin
                mul_a = $signed({{(MUL_A_W-DIFF_W){1'b0}}, g_mag});
                mul_b = $signed(MUL_B_W'(dt_reg));
            end
            S_GREC: begin
                mul_a = $signed(MUL_A_W'(rem_reg >> GQ_SHIFT));
                mul_b = $signed(MUL_B_W'(GYRO_RECIP));
            end
            S_GCHK: begin
                mul_a = $signed(MUL_A_W'(quo_reg));
                mul_b = $signed(MUL_B_W'(GYRO_DIV));
            end
            S_BL1: begin
                mul_a = MUL_A_W'(ang_sel) + MUL_A_W'(dlt_sel);
                mul_b = $signed(MUL_B_W'(cfg.alpha));
            end
            S_BL2: begin
                mul_a = MUL_A_W'(accel_sel);
                mul_b = MUL_B_W'(ALPHA_ONE) - $signed(MUL_B_W'(cfg.alpha));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // ---- square root step ----
    logic [NSQ_W:0]   root_trial;
    logic             root_ge;
    logic [NSQ_W-1:0] r_next, n_next;
    logic [NSQ_W-1:0] sq_sum;

    assign sq_sum     = NSQ_W'(acc_reg[33:0] + prod[33:0]) << SQ_SHIFT;
    assign root_trial = {1'b0, r_reg} + {1'b0, b_reg};
    assign root_ge    = {1'b0, n_reg} >= root_trial;
    assign n_next     = root_ge ? NSQ_W'({1'b0, n_reg} - root_trial) : n_reg;
    assign r_next     = root_ge ? (r_reg >> 1) + b_reg : (r_reg >> 1);

    // ---- CORDIC step ----
    logic signed [31:0] xs, ys, x_next, y_next, z_next, atan_val;

    always_comb begin
        xs       = x_reg >>> cnt_reg;
        ys       = y_reg >>> cnt_reg;
        atan_val = atan_deg(cnt_reg);
        if (y_reg > 0) begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + atan_val;
        end else begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - atan_val;
        end
    end

    logic signed [32:0]        z_rnd;
    logic signed [ANGLE_W-1:0] tilt_val;

    assign z_rnd    = ($signed({z_reg[31], z_reg}) + 33'(RND_ADD)) >>> RND_SH;
    assign tilt_val = (num_sel == '0) ? '0 : z_rnd[ANGLE_W-1:0];

    // ---- gyro quotient correction ----
    logic [DIVD_W-1:0] gyro_rem;
    logic              gyro_up;
    logic [QUO_W-1:0]  quo_fix;
    logic signed [ANGLE_W-1:0] delta_val;

    // estimate is low by at most one: bump it when the remainder still holds a divisor
    assign gyro_rem  = rem_reg - prod[DIVD_W-1:0];
    assign gyro_up   = gyro_rem >= DIVD_W'(GYRO_DIV);
    assign quo_fix   = quo_reg + QUO_W'(gyro_up);
    assign delta_val = g_sel[DIFF_W-1] ? -ANGLE_W'(quo_fix) : ANGLE_W'(quo_fix);

    // ---- blend ----
    logic signed [PROD_W-1:0] bl_sum, bl_sh;
    logic signed [ANGLE_W-1:0] bl_sat;

    always_comb begin
        bl_sum = acc_reg + prod + PROD_W'(16384);
        bl_sh  = bl_sum >>> 15;
        if (bl_sh > PROD_W'(64'sd2147483647))
            bl_sat = 32'sh7fffffff;
        else if (bl_sh < -PROD_W'(64'sd2147483648))
            bl_sat = 32'sh80000000;
        else
            bl_sat = bl_sh[ANGLE_W-1:0];
    end

    // ---- sequencer ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            roll_reg    <= '0;
            pitch_reg   <= '0;
            yaw_reg     <= '0;
            tsel_reg    <= 1'b0;
            bsel_reg    <= 1'b0;
            gsel_reg    <= '0;
            cnt_reg     <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        first_reg <= s_first_sample;
                        ax_reg <= DIFF_W'(s_accel_x) - DIFF_W'(cfg.acc_off_x);
                        ay_reg <= DIFF_W'(s_accel_y) - DIFF_W'(cfg.acc_off_y);
                        az_reg <= DIFF_W'(s_accel_z) - DIFF_W'(cfg.acc_off_z);
                        gx_reg <= DIFF_W'(s_gyro_x) - DIFF_W'(cfg.gyr_off_x);
                        gy_reg <= DIFF_W'(s_gyro_y) - DIFF_W'(cfg.gyr_off_y);
                        gz_reg <= DIFF_W'(s_gyro_z) - DIFF_W'(cfg.gyr_off_z);
                        dt_reg <= s_elapsed_us;
                        tsel_reg  <= 1'b0;
                        state_reg <= S_SQP;
                    end
                end
                S_SQP: begin
                    acc_reg   <= prod;
                    state_reg <= S_SQQ;
                end
                S_SQQ: begin
                    n_reg     <= sq_sum;
                    r_reg     <= '0;
                    b_reg     <= NSQ_W'(1) << (NSQ_W - 1);
                    state_reg <= S_ROOT;
                end
                S_ROOT: begin
                    n_reg <= n_next;
                    r_reg <= r_next;
                    b_reg <= b_reg >> 2;
                    if (b_reg[0]) begin
                        // root done: start CORDIC on (root, num << 12)
                        x_reg     <= 32'(r_next);
                        y_reg     <= 32'(num_sel) <<< Y_SHIFT;
                        z_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_CORD;
                    end
                end
                S_CORD: begin
                    x_reg   <= x_next;
                    y_reg   <= y_next;
                    z_reg   <= z_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                        state_reg <= S_TILT;
                end
                S_TILT: begin
                    if (!tsel_reg) begin
                        acc_pitch_reg <= tilt_val;
                        tsel_reg      <= 1'b1;
                        state_reg     <= S_SQP;
                    end else if (first_reg) begin
                        // seed from accel, drop gyro
                        roll_reg    <= -tilt_val;
                        pitch_reg   <= acc_pitch_reg;
                        yaw_reg     <= '0;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_OUT;
                    end else begin
                        acc_roll_reg <= -tilt_val;
                        gsel_reg     <= '0;
                        state_reg    <= S_GMUL;
                    end
                end
                S_GMUL: begin
                    rem_reg   <= (DIVD_W'(prod[32:0]) << ANGLE_FRAC_BITS) + DIVD_W'(GYRO_HALF);
                    state_reg <= S_GREC;
                end
                S_GREC: begin
                    quo_reg   <= prod[RECIP_SH +: QUO_W];
                    state_reg <= S_GCHK;
                end
                S_GCHK: begin
                    case (gsel_reg)
                        2'd0:    dx_reg <= delta_val;
                        2'd1:    dy_reg <= delta_val;
                        default: dz_reg <= delta_val;
                    endcase
                    if (gsel_reg == 2'd2) begin
                        bsel_reg  <= 1'b0;
                        state_reg <= S_BL1;
                    end else begin
                        gsel_reg  <= gsel_reg + 1'b1;
                        state_reg <= S_GMUL;
                    end
                end
                S_BL1: begin
                    acc_reg   <= prod;
                    state_reg <= S_BL2;
                end
                S_BL2: begin
                    if (!bsel_reg) begin
                        roll_reg  <= bl_sat;
                        bsel_reg  <= 1'b1;
                        state_reg <= S_BL1;
                    end else begin
                        pitch_reg   <= bl_sat;
                        yaw_reg     <= yaw_reg + dz_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_roll_deg  = roll_reg;
    assign m_pitch_deg = pitch_reg;
    assign m_yaw_deg   = yaw_reg;

endmodule

// ----- rtl/ctf_checker.sv -----
// Port-level checks for the tilt filter core, bound to the top level.
// Depends on ctf_pkg and complementary_tilt_filter_core.
module ctf_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic signed [ctf_pkg::ANGLE_W-1:0] m_roll_deg,
    input logic signed [ctf_pkg::ANGLE_W-1:0] m_pitch_deg,
    input logic signed [ctf_pkg::ANGLE_W-1:0] m_yaw_deg
);
    import ctf_pkg::*;

    // one word in flight: never ready while a result is shown
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while result pending");

    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (!m_valid && !s_ready))
        else $error("result or ready right after accept");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_roll_deg)
            && $stable(m_pitch_deg) && $stable(m_yaw_deg)))
        else $error("stalled result changed");

    a_back_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready) |=> s_ready)
        else $error("not idle after result taken");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid && s_ready))
        else $error("reset did not clear handshake");

endmodule

bind complementary_tilt_filter_core ctf_checker u_ctf_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_roll_deg  (m_roll_deg),
    .m_pitch_deg (m_pitch_deg),
    .m_yaw_deg   (m_yaw_deg)
);
